>>> hdl/four_level_page_table_walker_core_macros.svh
// assertion macros for the walker control module
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH

// property that holds at every clock edge out of reset
`define PTW_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define PTW_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/ptw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    // pool geometry
    localparam int TABLE_PAGES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int TBL_W             = $clog2(TABLE_PAGES);
    localparam int CNT_W             = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W            = TBL_W + IDX_W;
    localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;

    // address and descriptor layout
    localparam int PAGE_SHIFT = 12;
    localparam int VA_W       = 48;
    localparam int VPN_W      = VA_W - PAGE_SHIFT;
    localparam int DESC_W     = 64;
    localparam logic [PAGE_SHIFT-1:0] DESC_LINK_LOW = 12'h003;

    typedef enum logic [1:0] {
        OP_MAP    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_POOL_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_RD,
        S_CHK,
        S_RESP
    } state_t;

    // request to the table store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DESC_W-1:0] wr_data;
    } mem_req_t;

    // result handed from the walker to the output register
    typedef struct packed {
        status_t           status;
        logic [DESC_W-1:0] leaf_entry;
    } result_t;

    // 9-bit table index for one level of the walk
    function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = vpn[4*IDX_W-1:3*IDX_W];
            2'd1:    idx = vpn[3*IDX_W-1:2*IDX_W];
            2'd2:    idx = vpn[2*IDX_W-1:IDX_W];
            default: idx = vpn[IDX_W-1:0];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ptw_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ptw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [47:0] virt_addr;
    logic [47:0] phys_addr;
    logic [63:0] attr_flags;

    modport source (output valid, output opcode, output virt_addr, output phys_addr,
                    output attr_flags, input ready);
    modport sink (input valid, input opcode, input virt_addr, input phys_addr,
                  input attr_flags, output ready);
endinterface

`default_nettype wire

>>> hdl/ptw_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ptw_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] leaf_entry;

    modport source (output valid, output status, output leaf_entry, input ready);
    modport sink (input valid, input status, input leaf_entry, output ready);
endinterface

`default_nettype wire

>>> hdl/four_level_page_table_walker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  fields                                        handshake
// req      in   opcode, virt_addr, phys_addr, attr_flags      valid/ready
// rsp      out  status, leaf_entry                            valid/ready
//
// a walk through existing tables makes four dependent store reads on the single read port,
// each a read state then a check state, before rsp.valid rises from the output register
// each table taken from the pool is cleared first, one entry a cycle
// clear and unused opcodes go straight from idle to the response state; req.ready is high only when idle
// reset clears the pool count and root flag; the store itself is not cleared
// a stalled rsp holds its word; the next req word is taken meanwhile

module four_level_page_table_walker_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ptw_req_if.sink     req,
    ptw_rsp_if.source   rsp
);
    import ptw_pkg::*;

    mem_req_t           mem_req;
    logic [DESC_W-1:0]  mem_rd_data;
    result_t            res;
    logic               res_valid;
    logic               res_ready;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [DESC_W-1:0]  out_leaf_reg, out_leaf_next;

    ptw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

    ptw_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // output register, loads when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_leaf_next   = out_leaf_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res.status;
            out_leaf_next   = res.leaf_entry;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_leaf_reg   <= out_leaf_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.leaf_entry = out_leaf_reg;

endmodule

`default_nettype wire

>>> hdl/ptw_store.sv
`timescale 1ns / 1ps
`default_nettype none

module ptw_store (
    input  wire logic               clk,
    input  wire ptw_pkg::mem_req_t  req,
    output logic [63:0]             rd_data
);
    import ptw_pkg::*;

    logic [DESC_W-1:0] mem [STORE_DEPTH];
    logic [DESC_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/ptw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_core_macros.svh"

module ptw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ptw_req_if.sink                 req,
    output ptw_pkg::mem_req_t       mem_req,
    input  wire logic [63:0]        mem_rd_data,
    output ptw_pkg::result_t        res,
    output logic                    res_valid,
    input  wire logic               res_ready
);
    import ptw_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VPN_W-1:0]   vpn_reg, vpn_next;
    logic [DESC_W-1:0]  leaf_val_reg, leaf_val_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [TBL_W-1:0]   tbl_reg, tbl_next;
    logic [TBL_W-1:0]   fresh_reg, fresh_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]   next_free_reg, next_free_next;
    logic               root_present_reg, root_present_next;
    status_t            res_status_reg, res_status_next;
    logic [DESC_W-1:0]  res_leaf_reg, res_leaf_next;

    logic               accept;
    op_t                req_op;
    logic               pool_empty;
    logic [VPN_W-1:0]   next_tbl;
    logic               present;
    logic               last_clr;
    logic               at_leaf;
    logic [IDX_W-1:0]   cur_idx;
    logic [DESC_W-1:0]  link_desc;

    // decode of the current word and walk position
    assign accept     = req.valid && req.ready;
    assign req_op     = op_t'(req.opcode);
    assign pool_empty = next_free_reg >= CNT_W'(TABLE_PAGES);
    assign next_tbl   = mem_rd_data[VA_W-1:PAGE_SHIFT];
    assign present    = mem_rd_data[0] && (next_tbl < VPN_W'(TABLE_PAGES));
    assign last_clr   = clr_cnt_reg == IDX_W'(ENTRIES_PER_TABLE - 1);
    assign at_leaf    = lvl_reg == 2'd3;
    assign cur_idx    = level_index(vpn_reg, lvl_reg);
    assign link_desc  = {{(DESC_W - PAGE_SHIFT - TBL_W){1'b0}},
                         next_free_reg[TBL_W-1:0], DESC_LINK_LOW};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_op)
                        OP_MAP:
                        begin
                            if (root_present_reg)
                                state_next = S_RD;
                            else if (pool_empty)
                                state_next = S_RESP;
                            else
                                state_next = S_CLR;
                        end
                        OP_LOOKUP:
                            state_next = root_present_reg ? S_RD : S_RESP;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_CLR:
                state_next = last_clr ? S_RD : S_CLR;
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                if (at_leaf)
                    state_next = S_RESP;
                else if (present)
                    state_next = S_RD;
                else if (op_reg == OP_MAP && !pool_empty)
                    state_next = S_CLR;
                else
                    state_next = S_RESP;
            end
            S_RESP:
                state_next = res_ready ? S_IDLE : S_RESP;
            default:
                state_next = S_IDLE;
        endcase
    end

    // walk registers, pool counter and result
    always_comb
    begin
        op_next           = op_reg;
        vpn_next          = vpn_reg;
        leaf_val_next     = leaf_val_reg;
        lvl_next          = lvl_reg;
        tbl_next          = tbl_reg;
        fresh_next        = fresh_reg;
        clr_cnt_next      = clr_cnt_reg;
        next_free_next    = next_free_reg;
        root_present_next = root_present_reg;
        res_status_next   = res_status_reg;
        res_leaf_next     = res_leaf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req_op;
                    vpn_next        = req.virt_addr[VA_W-1:PAGE_SHIFT];
                    leaf_val_next   = {{(DESC_W - VA_W){1'b0}},
                                       req.phys_addr[VA_W-1:PAGE_SHIFT],
                                       {PAGE_SHIFT{1'b0}}} | req.attr_flags;
                    lvl_next        = 2'd0;
                    tbl_next        = '0;
                    clr_cnt_next    = '0;
                    res_status_next = ST_OK;
                    res_leaf_next   = '0;
                    case (req_op)
                        OP_CLEAR:
                        begin
                            next_free_next    = '0;
                            root_present_next = 1'b0;
                        end
                        OP_LOOKUP:
                        begin
                            if (!root_present_reg)
                                res_status_next = ST_NOT_MAPPED;
                        end
                        OP_MAP:
                        begin
                            if (!root_present_reg)
                            begin
                                if (pool_empty)
                                begin
                                    res_status_next = ST_POOL_EMPTY;
                                end
                                else
                                begin
                                    fresh_next        = next_free_reg[TBL_W-1:0];
                                    next_free_next    = next_free_reg + 1'b1;
                                    root_present_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLR:
                clr_cnt_next = clr_cnt_reg + 1'b1;
            S_CHK:
            begin
                if (at_leaf)
                begin
                    res_status_next = ST_OK;
                    res_leaf_next   = (op_reg == OP_MAP) ? leaf_val_reg : mem_rd_data;
                end
                else if (present)
                begin
                    tbl_next = next_tbl[TBL_W-1:0];
                    lvl_next = lvl_reg + 2'd1;
                end
                else if (op_reg != OP_MAP)
                begin
                    res_status_next = ST_NOT_MAPPED;
                end
                else if (pool_empty)
                begin
                    res_status_next = ST_POOL_EMPTY;
                end
                else
                begin
                    fresh_next     = next_free_reg[TBL_W-1:0];
                    tbl_next       = next_free_reg[TBL_W-1:0];
                    next_free_next = next_free_reg + 1'b1;
                    lvl_next       = lvl_reg + 2'd1;
                    clr_cnt_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // store requests and handshakes
    always_comb
    begin
        mem_req   = '0;
        req.ready = state_reg == S_IDLE;
        res_valid = state_reg == S_RESP;
        case (state_reg)
            S_CLR:
            begin
                // zero one entry of the table just taken
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {fresh_reg, clr_cnt_reg};
                mem_req.wr_data = '0;
            end
            S_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = {tbl_reg, cur_idx};
            end
            S_CHK:
            begin
                if (op_reg == OP_MAP)
                begin
                    // leaf write, or link to a newly taken table
                    if (at_leaf)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = {tbl_reg, cur_idx};
                        mem_req.wr_data = leaf_val_reg;
                    end
                    else if (!present && !pool_empty)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = {tbl_reg, cur_idx};
                        mem_req.wr_data = link_desc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.status     = res_status_reg;
    assign res.leaf_entry = res_leaf_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            next_free_reg    <= '0;
            root_present_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            next_free_reg    <= next_free_next;
            root_present_reg <= root_present_next;
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        vpn_reg        <= vpn_next;
        leaf_val_reg   <= leaf_val_next;
        lvl_reg        <= lvl_next;
        tbl_reg        <= tbl_next;
        fresh_reg      <= fresh_next;
        clr_cnt_reg    <= clr_cnt_next;
        res_status_reg <= res_status_next;
        res_leaf_reg   <= res_leaf_next;
    end

    `PTW_ASSERT_ALWAYS(a_no_rd_wr_overlap, !(mem_req.rd_en && mem_req.wr_en), "store read and write in one cycle")
    `PTW_ASSERT_IMPL(a_root_owns_table, root_present_reg, next_free_reg != '0, "root present with empty pool count")
    `PTW_ASSERT_ALWAYS(a_pool_bound, next_free_reg <= CNT_W'(TABLE_PAGES), "pool count beyond pool size")
    `PTW_ASSERT_IMPL(a_fail_zero_leaf, res_valid && (res.status != ST_OK), res.leaf_entry == '0, "failed word with nonzero leaf")

endmodule

`default_nettype wire

>>> test/four_level_page_table_walker_core_tb.sv
`timescale 1ns / 1ps

module four_level_page_table_walker_core_tb;
    import ptw_pkg::*;

    localparam int TARGET_ITEMS = 850;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        op_t         op;
        logic [47:0] va;
        logic [47:0] pa;
        logic [63:0] flags;
    } walk_cmd_t;

    typedef struct {
        status_t     status;
        logic [63:0] leaf;
    } walk_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ptw_req_if req_ch ();
    ptw_rsp_if rsp_ch ();

    four_level_page_table_walker_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the table pool
    logic [63:0]  shadow_tables [0:STORE_DEPTH-1];
    int unsigned  shadow_next_free;
    bit           shadow_root;

    walk_cmd_t    pending_cmds [$];
    walk_result_t expected_results [$];

    // stimulus planning state
    logic [47:0]  mapped_va [$];
    logic [8:0]   idx_pool [0:2][0:1];
    int           planned_items;

    // run statistics
    int mismatch_count;
    int n_map, n_lookup, n_clear, n_ignored;
    int n_ok, n_not_mapped, n_pool_empty;
    int results_seen;

    // 9-bit index of one walk level, level 0 being the root
    function automatic logic [8:0] va_index(input logic [47:0] va, input int lvl);
        return va[47 - 9*lvl -: 9];
    endfunction

    // hand out the next pool table, zeroed; 0 when the pool is used up
    function automatic bit claim_table(output int unsigned t);
        t = 0;
        if (shadow_next_free >= TABLE_PAGES)
            return 1'b0;
        t = shadow_next_free;
        shadow_next_free++;
        for (int i = 0; i < ENTRIES_PER_TABLE; i++)
            shadow_tables[t*ENTRIES_PER_TABLE + i] = '0;
        return 1'b1;
    endfunction

    // walk the shadow tables for one request and return the expected word
    function automatic walk_result_t predict_walk(input walk_cmd_t c);
        walk_result_t r;
        int unsigned  tbl;
        int unsigned  fresh;
        int unsigned  pos;
        logic [63:0]  e;
        logic [35:0]  next_tbl;
        r.status = ST_OK;
        r.leaf   = '0;
        if (c.op == OP_CLEAR)
        begin
            shadow_next_free = 0;
            shadow_root      = 1'b0;
            return r;
        end
        if (c.op == OP_NONE)
            return r;
        if (!shadow_root)
        begin
            if (c.op == OP_LOOKUP)
            begin
                r.status = ST_NOT_MAPPED;
                return r;
            end
            if (!claim_table(fresh))
            begin
                r.status = ST_POOL_EMPTY;
                return r;
            end
            shadow_root = 1'b1;
        end
        tbl = 0;
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            pos      = tbl*ENTRIES_PER_TABLE + va_index(c.va, lvl);
            e        = shadow_tables[pos];
            next_tbl = e[47:12];
            if (!e[0] || next_tbl >= TABLE_PAGES)
            begin
                if (c.op == OP_LOOKUP)
                begin
                    r.status = ST_NOT_MAPPED;
                    return r;
                end
                if (!claim_table(fresh))
                begin
                    r.status = ST_POOL_EMPTY;
                    return r;
                end
                shadow_tables[pos] = (64'(fresh) << PAGE_SHIFT) | 64'(DESC_LINK_LOW);
                tbl = fresh;
            end
            else
            begin
                tbl = next_tbl;
            end
        end
        pos = tbl*ENTRIES_PER_TABLE + va_index(c.va, 3);
        if (c.op == OP_MAP)
            shadow_tables[pos] = {16'h0, c.pa[47:12], 12'h000} | c.flags;
        r.leaf = shadow_tables[pos];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // wide value with the extremes mixed in
    function automatic logic [63:0] pick_wide();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return rand64();
    endfunction

    function automatic logic [47:0] rand_va();
        logic [63:0] w;
        w = rand64();
        return w[47:0];
    endfunction

    // address drawn from the small per-phase index pools
    function automatic logic [47:0] pool_va();
        logic [8:0]  i3;
        logic [11:0] lo;
        i3 = $urandom_range(0, 511);
        lo = $urandom_range(0, 4095);
        return {idx_pool[0][$urandom_range(0, 1)], idx_pool[1][$urandom_range(0, 1)],
                idx_pool[2][$urandom_range(0, 1)], i3, lo};
    endfunction

    function automatic logic [47:0] any_mapped_va();
        return mapped_va[$urandom_range(0, mapped_va.size() - 1)];
    endfunction

    task automatic push_cmd(input op_t op, input logic [47:0] va, input logic [63:0] pa,
                            input logic [63:0] flags);
        walk_cmd_t c;
        c.op    = op;
        c.va    = va;
        c.pa    = pa[47:0];
        c.flags = flags;
        pending_cmds.push_back(c);
        if (op != OP_NONE)
            planned_items++;
        if (op == OP_MAP)
            mapped_va.push_back(va);
        if (op == OP_CLEAR)
            mapped_va.delete();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    // request driver
    walk_cmd_t cur_cmd;
    int        tx_wait;
    bit        tx_burst;

    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_valid;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.opcode     <= OP_NONE;
            req_ch.virt_addr  <= '0;
            req_ch.phys_addr  <= '0;
            req_ch.attr_flags <= '0;
            tx_wait  = 0;
            tx_burst = 1'b0;
        end
        else
        begin
            nxt_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(predict_walk(cur_cmd));
                case (cur_cmd.op)
                    OP_MAP:    n_map++;
                    OP_LOOKUP: n_lookup++;
                    OP_CLEAR:  n_clear++;
                    default:   n_ignored++;
                endcase
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 12);
            end
            if (!nxt_valid)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    nxt_valid = 1'b1;
                    req_ch.opcode     <= cur_cmd.op;
                    req_ch.virt_addr  <= cur_cmd.va;
                    req_ch.phys_addr  <= cur_cmd.pa;
                    req_ch.attr_flags <= cur_cmd.flags;
                end
            end
            req_ch.valid <= nxt_valid;
        end
    end

    // response monitor and checker
    int rx_wait;
    int hold_left;
    bit hold_done;
    bit rx_burst;

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        logic nxt_ready;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
            hold_done = 1'b0;
            rx_burst  = 1'b0;
        end
        else
        begin
            nxt_ready = rsp_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                case (rsp_ch.status)
                    ST_OK:         n_ok++;
                    ST_NOT_MAPPED: n_not_mapped++;
                    ST_POOL_EMPTY: n_pool_empty++;
                    default: ;
                endcase
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected word", rsp_ch.leaf_entry, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                    if (rsp_ch.leaf_entry !== want.leaf)
                        report_mismatch("leaf_entry", rsp_ch.leaf_entry, want.leaf);
                end
                nxt_ready = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
                // one long back-pressure stretch so the walker backs up
                if (!hold_done && results_seen == HOLD_AFTER)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (!nxt_ready)
            begin
                if (rx_wait > 0)
                    rx_wait--;
                else
                    nxt_ready = 1'b1;
            end
            rsp_ch.ready <= nxt_ready;
        end
    end

    // watchdog on cycles without any accepted word
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no progress for %0d cycles", STALL_LIMIT);
                $display("four_level_page_table_walker_core test failed");
                $finish;
            end
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin
        logic [47:0] va;
        logic [63:0] w;
        int          phase;
        int          len;
        int          sel;

        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_NONE;
        req_ch.virt_addr  = '0;
        req_ch.phys_addr  = '0;
        req_ch.attr_flags = '0;
        rsp_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        mismatch_count    = 0;
        planned_items     = 0;
        shadow_next_free  = 0;
        shadow_root       = 1'b0;

        // directed: empty table, extremes, zero leaf, partial walk, unused opcode
        push_cmd(OP_LOOKUP, '1, '0, '0);
        push_cmd(OP_MAP, '1, '1, '1);
        push_cmd(OP_MAP, '0, 64'hFFF, '0);
        push_cmd(OP_LOOKUP, '0, '1, '1);
        push_cmd(OP_LOOKUP, {9'h1FF, 9'h000, 30'h0}, '0, '0);
        push_cmd(OP_NONE, '1, '1, '1);
        push_cmd(OP_MAP, '1, 64'h0000_5555_5555_5000, 64'h8000_0000_0000_0001);
        push_cmd(OP_LOOKUP, {36'hFFFFFFFFF, 12'h000}, '0, '0);
        push_cmd(OP_CLEAR, '0, '0, '0);
        push_cmd(OP_LOOKUP, '1, '0, '0);

        // random phases; every seventh one runs the pool dry
        phase = 0;
        while (planned_items < TARGET_ITEMS)
        begin
            if (phase % 7 == 0)
            begin
                push_cmd(OP_CLEAR, rand_va(), pick_wide(), pick_wide());
                for (int k = 0; k < 40; k++)
                begin
                    sel = $urandom_range(0, 2);
                    if (sel == 0 && mapped_va.size() > 0)
                    begin
                        push_cmd(OP_LOOKUP, any_mapped_va(), pick_wide(), pick_wide());
                    end
                    else if (sel == 1 && mapped_va.size() > 0)
                    begin
                        // same root slot, new lower path: partial allocations near the end
                        va = any_mapped_va();
                        w = rand64();
                        va[38:0] = w[38:0];
                        push_cmd(OP_MAP, va, pick_wide(), pick_wide());
                    end
                    else
                    begin
                        push_cmd(OP_MAP, rand_va(), pick_wide(), pick_wide());
                    end
                end
                for (int k = 0; k < 4; k++)
                    push_cmd(OP_LOOKUP, any_mapped_va(), pick_wide(), pick_wide());
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    push_cmd(OP_CLEAR, rand_va(), pick_wide(), pick_wide());
                for (int l = 0; l < 3; l++)
                begin
                    idx_pool[l][0] = $urandom_range(0, 511);
                    idx_pool[l][1] = $urandom_range(0, 511);
                end
                len = $urandom_range(30, 50);
                for (int k = 0; k < len; k++)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 40)
                        push_cmd(OP_MAP, pool_va(), pick_wide(), pick_wide());
                    else if (sel < 70 && mapped_va.size() > 0)
                        push_cmd(OP_LOOKUP, any_mapped_va(), pick_wide(), pick_wide());
                    else if (sel < 80)
                        push_cmd(OP_LOOKUP, pool_va(), pick_wide(), pick_wide());
                    else if (sel < 88)
                        push_cmd(OP_LOOKUP, rand_va(), pick_wide(), pick_wide());
                    else if (sel < 91)
                        push_cmd(OP_MAP, rand_va(), pick_wide(), pick_wide());
                    else if (sel < 95)
                        push_cmd(OP_NONE, rand_va(), pick_wide(), pick_wide());
                    else if (sel < 97)
                        push_cmd(OP_CLEAR, rand_va(), pick_wide(), pick_wide());
                    else if (mapped_va.size() > 0)
                        push_cmd(OP_MAP, any_mapped_va(), pick_wide(), pick_wide());
                    else
                        push_cmd(OP_LOOKUP, pool_va(), pick_wide(), pick_wide());
                end
            end
            phase++;
        end

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain
        while (pending_cmds.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: %0d map, %0d lookup, %0d clear, %0d unused opcode",
                 n_map, n_lookup, n_clear, n_ignored);
        $display("results: %0d ok, %0d not mapped, %0d pool exhausted, %0d mismatches",
                 n_ok, n_not_mapped, n_pool_empty, mismatch_count);
        if (mismatch_count == 0)
            $display("four_level_page_table_walker_core test passed");
        else
            $display("four_level_page_table_walker_core test failed");
        $finish;
    end

endmodule
